// ----- rtl/core/audio_channel_remix_matrix_top_assert.svh -----
// Assertion macros for the audio channel remix matrix core.
// Included by the top level; expects aclk and aresetn in scope.
`ifndef AUDIO_CHANNEL_REMIX_MATRIX_TOP_ASSERT_SVH
`define AUDIO_CHANNEL_REMIX_MATRIX_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset
`define ACRM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);
// Check an implication whose consequence holds in the next cycle
`define ACRM_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (conseq)) else $error(msg);
`else
`define ACRM_ASSERT(label, prop, msg)
`define ACRM_ASSERT_NEXT(label, cond, conseq, msg)
`endif
`endif

// ----- rtl/core/acrm_pkg.sv -----
// Shared types and fixed field layout for the audio channel remix matrix.
// No dependencies.
`default_nettype none

package acrm_pkg;

    // Field widths of the stream payloads
    localparam int ROW_W      = 5;
    localparam int COL_W      = 5;
    localparam int SAMPLE_W   = 16;
    localparam int CHANNEL_W  = 5;
    localparam int COUNT_W    = 6;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 24;
    localparam int PROD_W     = 32;

    // Input item kinds carried in s_tuser
    localparam logic MODE_WEIGHT = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_MAC   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_SAT   = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/audio_channel_remix_matrix_top.sv -----
// Audio channel remix matrix: sequencer, coefficient and frame memories, shared MAC.
// Depends on acrm_pkg and audio_channel_remix_matrix_top_assert.svh.
//
// After reset the block runs a clearing pass that loads the identity matrix into the
// coefficient memory, one entry per cycle; s_tready stays low meanwhile, configuration
// writes are taken. A weight transaction or a sample that does not close a frame leaves
// the block idle. The sample that closes a frame starts the mix: one shared
// multiply-accumulate unit walks the coefficient memory row by row, count products per
// output channel, followed by pipeline drain and saturation. Results leave through an
// output register, and a new input transaction is taken once the last row is in that
// register.
`default_nettype none

module audio_channel_remix_matrix_top
    import acrm_pkg::*;
#(
    parameter int MAX_CHANNELS   = 32,
    parameter int COEF_FRAC_BITS = 12
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration: channel_count
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [COUNT_W-1:0]   cfg_data,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata, low bit up: row[4:0], col[9:5], weight[25:10], sample[41:26], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: mode (0 weight write, 1 sample)
    input  wire logic                 s_tuser,
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata, low bit up: channel[4:0], mixed[20:5], zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    localparam int CW      = $clog2(MAX_CHANNELS);
    localparam int PW      = CW + 1;
    localparam int AW      = 2 * CW;
    localparam int ACC_W   = PROD_W + CW;
    localparam int ONE_INT = (COEF_FRAC_BITS >= 15) ? 32767 : (1 << COEF_FRAC_BITS);
    localparam logic [SAMPLE_W-1:0]   COEF_ONE = SAMPLE_W'(ONE_INT);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);

    // Memories
    logic [SAMPLE_W-1:0] coef_mem [2**AW];
    logic [SAMPLE_W-1:0] buf_mem  [2**CW];

    // Control registers
    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     u_reg, u_next;
    logic [CW-1:0]     v_reg, v_next;
    logic              p1_valid_reg, p1_valid_next;
    logic              p2_valid_reg;
    logic              m_valid_reg, m_valid_next;

    // Pipeline flags and payload registers
    logic              p1_first_reg, p1_last_reg;
    logic              p2_first_reg, p2_last_reg;
    logic [SAMPLE_W-1:0] coef_q_reg, buf_q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [CHANNEL_W-1:0] m_chan_reg;
    logic [SAMPLE_W-1:0]  m_mixed_reg;
    logic                 m_last_reg;

    // Input field views
    logic [ROW_W-1:0]    in_row;
    logic [COL_W-1:0]    in_col;
    logic [SAMPLE_W-1:0] in_weight, in_sample;
    assign in_row    = s_tdata[4:0];
    assign in_col    = s_tdata[9:5];
    assign in_weight = s_tdata[25:10];
    assign in_sample = s_tdata[41:26];

    // Effective channel count, clamped to 1..MAX_CHANNELS
    logic [6:0]    cnt_wide;
    logic [PW-1:0] cnt_eff, cnt_m1;
    always_comb begin
        cnt_wide = {1'b0, count_reg};
        if (count_reg == '0) begin
            cnt_eff = PW'(1);
        end else if (cnt_wide > 7'(MAX_CHANNELS)) begin
            cnt_eff = PW'(MAX_CHANNELS);
        end else begin
            cnt_eff = PW'(cnt_wide);
        end
        cnt_m1 = cnt_eff - PW'(1);
    end

    // Handshake decode
    logic s_accept, cfg_accept, w_accept, smp_accept, frame_close, w_in_range;
    logic [PW-1:0] pos_plus1;
    assign cfg_ready   = 1'b1;
    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign cfg_accept  = cfg_valid && cfg_ready;
    assign w_in_range  = (7'(in_row) < 7'(MAX_CHANNELS)) && (7'(in_col) < 7'(MAX_CHANNELS));
    assign w_accept    = s_accept && (s_tuser == MODE_WEIGHT);
    assign smp_accept  = s_accept && (s_tuser == MODE_SAMPLE);
    assign pos_plus1   = {1'b0, pos_reg} + PW'(1);
    assign frame_close = pos_plus1 >= cnt_eff;

    // Row and column ends of the MAC walk
    logic v_last, u_last;
    assign v_last = ({1'b0, v_reg} == cnt_m1);
    assign u_last = ({1'b0, u_reg} == cnt_m1);

    // Saturate the shifted sum
    logic signed [ACC_W-1:0]   acc_shift;
    logic [SAMPLE_W-1:0]       sat_val;
    logic                      out_free;
    always_comb begin
        acc_shift = acc_reg >>> COEF_FRAC_BITS;
        if (acc_shift > SAT_MAX) begin
            sat_val = SAMPLE_W'(SAT_MAX);
        end else if (acc_shift < SAT_MIN) begin
            sat_val = SAMPLE_W'(SAT_MIN);
        end else begin
            sat_val = acc_shift[SAMPLE_W-1:0];
        end
    end
    assign out_free = !m_valid_reg || m_tready;

    // Memory port selection
    logic              coef_we;
    logic [AW-1:0]     coef_waddr;
    logic [SAMPLE_W-1:0] coef_wdata;
    logic              res_load;
    always_comb begin
        coef_we    = 1'b0;
        coef_waddr = {CW'(in_row), CW'(in_col)};
        coef_wdata = in_weight;
        if (state_reg == ST_CLEAR) begin
            coef_we    = 1'b1;
            coef_waddr = clr_reg;
            coef_wdata = (clr_reg[AW-1:CW] == clr_reg[CW-1:0]) ? COEF_ONE : '0;
        end else if (w_accept && w_in_range) begin
            coef_we = 1'b1;
        end
    end

    // Sequencer next state
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        p1_valid_next = 1'b0;
        res_load      = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (smp_accept) begin
                    if (frame_close) begin
                        pos_next   = '0;
                        u_next     = '0;
                        v_next     = '0;
                        state_next = ST_MAC;
                    end else begin
                        pos_next = pos_plus1[CW-1:0];
                    end
                end
            end
            ST_MAC: begin
                // issue one coefficient and sample read per cycle
                p1_valid_next = 1'b1;
                v_next        = v_reg + CW'(1);
                if (v_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (p2_valid_reg && p2_last_reg) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT: begin
                if (out_free) begin
                    res_load = 1'b1;
                    if (u_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        u_next     = u_reg + CW'(1);
                        v_next     = '0;
                        state_next = ST_MAC;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // a count write restarts the frame
        if (cfg_accept) begin
            count_next = cfg_data;
            pos_next   = '0;
        end
    end

    // Output valid: load a result, drop it once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            count_reg    <= COUNT_W'(2);
            pos_reg      <= '0;
            u_reg        <= '0;
            v_reg        <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            u_reg        <= u_next;
            v_reg        <= v_next;
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p1_valid_reg;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Coefficient memory: one write port, registered read
    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        coef_q_reg <= coef_mem[{u_reg, v_reg}];
    end

    // Frame buffer: sample write, registered read
    always_ff @(posedge aclk) begin
        if (smp_accept) begin
            buf_mem[pos_reg] <= in_sample;
        end
        buf_q_reg <= buf_mem[v_reg];
    end

    // Multiply and accumulate pipeline
    always_ff @(posedge aclk) begin
        p1_first_reg <= (v_reg == '0);
        p1_last_reg  <= v_last;
        p2_first_reg <= p1_first_reg;
        p2_last_reg  <= p1_last_reg;
        prod_reg     <= $signed(coef_q_reg) * $signed(buf_q_reg);
        if (p2_valid_reg) begin
            if (p2_first_reg) begin
                acc_reg <= ACC_W'(prod_reg);
            end else begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_chan_reg  <= CHANNEL_W'(u_reg);
            m_mixed_reg <= sat_val;
            m_last_reg  <= u_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_mixed_reg, m_chan_reg};
    assign m_tlast  = m_last_reg;

    // Assertions
    `include "audio_channel_remix_matrix_top_assert.svh"

    `ACRM_ASSERT(a_pos_in_range, ({1'b0, pos_reg} < cnt_eff), "frame position past count")
    `ACRM_ASSERT(a_idle_drained, (!(state_reg == ST_IDLE) || (!p1_valid_reg && !p2_valid_reg)), "MAC pipeline busy while idle")
    `ACRM_ASSERT_NEXT(a_clear_done, (state_reg == ST_CLEAR && (&clr_reg)), (state_reg == ST_IDLE), "clearing pass did not end")
    `ACRM_ASSERT_NEXT(a_close_starts, (smp_accept && frame_close), (state_reg == ST_MAC && u_reg == '0 && v_reg == '0), "frame close did not start mix")

endmodule

`default_nettype wire

// ----- tb/tb_audio_channel_remix_matrix_top.sv -----
// Self-checking testbench for audio_channel_remix_matrix_top: streams weight writes and
// interleaved samples, predicts every remixed output and compares it on the result stream.
// Depends on acrm_pkg and the RTL of the block.
`default_nettype none

module tb_audio_channel_remix_matrix_top
    import acrm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CH           = 32;
    localparam int FRAC           = 12;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RANDOM_ITEMS   = 170;

    typedef struct {
        logic               mode;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic signed [15:0] weight;
        logic signed [15:0] sample;
    } remix_item_t;

    typedef struct {
        logic [CHANNEL_W-1:0] channel;
        logic signed [15:0]   mixed;
        logic                 frame_end;
    } mix_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // Mirror of the block state
    logic signed [15:0] coef_mirror [N_CH][N_CH];
    logic signed [15:0] frame_mirror [N_CH];
    int unsigned        frame_pos;
    logic [COUNT_W-1:0] chan_count;

    remix_item_t pending_items [$];
    mix_result_t mix_expected [$];
    remix_item_t tx_item;
    int unsigned tx_gap       = 0;
    int unsigned rx_wait      = 0;
    bit          tx_burst     = 1'b0;
    bit          rx_burst     = 1'b0;
    int unsigned queued_items = 0;
    int unsigned fail_count   = 0;
    int unsigned stall_cycles = 0;
    int unsigned cfg_plan [11] = '{3, 32, 5, 63, 1, 8, 33, 4, 2, 17, 6};

    always #4 aclk = ~aclk;

    audio_channel_remix_matrix_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clamp the programmed count to 1..N_CH
    function automatic int unsigned active_channels();
        int unsigned c;
        c = chan_count;
        if (c == 0) c = 1;
        if (c > N_CH) c = N_CH;
        return c;
    endfunction

    // Update the mirror with one accepted item and queue the mixed outputs it closes
    task automatic predict_remix(input remix_item_t it);
        int unsigned cnt;
        int unsigned pos;
        longint      acc;
        longint      y;
        mix_result_t r;
        if (it.mode == MODE_WEIGHT) begin
            coef_mirror[it.row][it.col] = it.weight;
            return;
        end
        cnt = active_channels();
        pos = frame_pos;
        if (pos >= N_CH) pos = N_CH - 1;
        frame_mirror[pos] = it.sample;
        if (pos + 1 < cnt) begin
            frame_pos = pos + 1;
            return;
        end
        frame_pos = 0;
        for (int u = 0; u < cnt; u++) begin
            acc = 0;
            for (int v = 0; v < cnt; v++)
                acc += longint'(coef_mirror[u][v]) * longint'(frame_mirror[v]);
            // Floor shift, then saturate to 16 bits
            y = acc >>> FRAC;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            r.channel   = CHANNEL_W'(u);
            r.mixed     = y[15:0];
            r.frame_end = (u + 1 == cnt);
            mix_expected.push_back(r);
        end
    endtask

    task automatic push_weight(input int r, input int c, input logic signed [15:0] w);
        remix_item_t it;
        it.mode   = MODE_WEIGHT;
        it.row    = ROW_W'(r);
        it.col    = COL_W'(c);
        it.weight = w;
        it.sample = 16'($urandom);
        pending_items.push_back(it);
        queued_items++;
    endtask

    task automatic push_sample(input logic signed [15:0] s);
        remix_item_t it;
        it.mode   = MODE_SAMPLE;
        it.row    = ROW_W'($urandom);
        it.col    = COL_W'($urandom);
        it.weight = 16'($urandom);
        it.sample = s;
        pending_items.push_back(it);
        queued_items++;
    endtask

    // Mostly moderate coefficients so sums stay in range, sometimes any value
    function automatic logic signed [15:0] rand_weight();
        if ($urandom_range(0, 2) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(0, 2047)) - 1024);
    endfunction

    // Hold until every queued transaction is accepted and every output has arrived
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || mix_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        chan_count = value;
        frame_pos  = 0;
        cfg_valid <= 1'b0;
    endtask

    // Driver: present queued items, with a random gap after each one
    always @(posedge aclk) begin
        logic        nxt_valid;
        remix_item_t nxt_item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            nxt_valid = s_tvalid;
            nxt_item  = tx_item;
            if (s_tvalid && s_tready) begin
                predict_remix(tx_item);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (tx_gap != 0) begin
                    tx_gap <= tx_gap - 1;
                end else if (pending_items.size() != 0) begin
                    nxt_item  = pending_items.pop_front();
                    nxt_valid = 1'b1;
                    if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
                    tx_gap <= tx_burst ? 0 : $urandom_range(0, 4);
                end
            end
            s_tvalid <= nxt_valid;
            tx_item  <= nxt_item;
            s_tdata  <= {6'b0, nxt_item.sample, nxt_item.weight, nxt_item.col, nxt_item.row};
            s_tuser  <= nxt_item.mode;
        end
    end

    // Monitor: check each result transaction, then stall ready for a random time
    always @(posedge aclk) begin
        mix_result_t got;
        mix_result_t want;
        int unsigned wait_n;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else begin
            wait_n = rx_wait;
            if (m_tvalid && m_tready) begin
                got.channel   = m_tdata[4:0];
                got.mixed     = m_tdata[20:5];
                got.frame_end = m_tlast;
                if (mix_expected.size() == 0) begin
                    $display("%0t: unexpected result: channel %0d mixed %0d last %0b",
                             $time, got.channel, got.mixed, got.frame_end);
                    fail_count++;
                end else begin
                    want = mix_expected.pop_front();
                    if (got.channel !== want.channel || got.mixed !== want.mixed ||
                        got.frame_end !== want.frame_end) begin
                        $display("%0t: mismatch: expected channel %0d mixed %0d last %0b,",
                                 $time, want.channel, want.mixed, want.frame_end,
                                 " actual channel %0d mixed %0d last %0b",
                                 got.channel, got.mixed, got.frame_end);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
                wait_n = rx_burst ? 0 : $urandom_range(0, 4);
            end
            if (wait_n != 0) begin
                m_tready <= 1'b0;
                rx_wait  <= wait_n - 1;
            end else begin
                m_tready <= 1'b1;
                rx_wait  <= 0;
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[audio_channel_remix_matrix_top] ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned directed_items;
        int unsigned phase;
        int unsigned cnt;
        int unsigned frames;
        int unsigned part;
        for (int u = 0; u < N_CH; u++) begin
            frame_mirror[u] = '0;
            for (int v = 0; v < N_CH; v++)
                coef_mirror[u][v] = (u == v) ? 16'sd4096 : 16'sd0;
        end
        frame_pos  = 0;
        chan_count = 2;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Identity matrix at reset passes the extremes through
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        // Extreme weights drive both saturation limits
        push_weight(0, 0, 16'sh7fff);
        push_weight(0, 1, 16'sh8000);
        push_weight(1, 0, 16'sh8000);
        push_weight(1, 1, 16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        push_sample(16'sh8000);
        push_sample(16'sh8000);
        // Far corners of the store, then floor rounding of a negative sum
        push_weight(31, 31, 16'sh1234);
        push_weight(31, 0, -16'sd1);
        push_weight(1, 1, 16'sd1);
        push_sample(16'sd0);
        push_sample(-16'sd1);
        // Leave a frame half done; the count write below restarts it
        push_sample(16'sd100);
        wait_idle();
        write_count(2);
        push_sample(16'sd2000);
        push_sample(-16'sd3000);
        wait_idle();
        // Zero count acts as a single channel
        write_count(0);
        push_weight(0, 0, 16'sh8000);
        push_sample(16'sd12345);
        push_sample(16'sh8000);
        directed_items = queued_items;

        // Random phases: one count setting each, frames with interleaved weight writes
        phase = 0;
        while (queued_items < directed_items + RANDOM_ITEMS) begin
            wait_idle();
            if (phase < $size(cfg_plan))
                write_count(COUNT_W'(cfg_plan[phase]));
            else
                write_count(COUNT_W'($urandom_range(1, 8)));
            cnt    = active_channels();
            frames = (cnt > 16) ? 1 : $urandom_range(1, 3);
            repeat (frames) begin
                repeat ($urandom_range(0, 3)) begin
                    if ($urandom_range(0, 3) == 0)
                        push_weight($urandom_range(0, 31), $urandom_range(0, 31), rand_weight());
                    else
                        push_weight($urandom_range(0, cnt - 1), $urandom_range(0, cnt - 1),
                                    rand_weight());
                end
                repeat (cnt) push_sample(16'($urandom));
            end
            // Now and then break off a frame before the next count write
            if (cnt > 1 && $urandom_range(0, 3) == 0) begin
                part = $urandom_range(1, cnt - 1);
                repeat (part) push_sample(16'($urandom));
            end
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[audio_channel_remix_matrix_top] OK");
        else
            $display("[audio_channel_remix_matrix_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl/core
rtl/core/acrm_pkg.sv
rtl/core/audio_channel_remix_matrix_top.sv
tb/tb_audio_channel_remix_matrix_top.sv
